>>> hdl/rpa_pkg.sv
// Package for the reference-counted page allocator.
// Field widths, request and status codes, register indexes and defaults.
// No dependencies.
package rpa_pkg;

   localparam int ADDR_W     = 34;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CNT_OUT_W  = 16;
   localparam int CSR_IDX_W  = 2;

   localparam int DEF_PAGE_COUNT = 32768;
   localparam int DEF_PAGE_BYTES = 4096;
   localparam int DEF_COUNT_BITS = 16;

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ADDREF = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RETURNED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd6;

   localparam logic [CSR_IDX_W-1:0] REG_REGION_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_USABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_TOP   = 2'd2;

   localparam logic [ADDR_W-1:0] RESET_REGION_BASE  = 34'h0_8000_0000;
   localparam logic [ADDR_W-1:0] RESET_FIRST_USABLE = 34'h0_8000_0000;
   localparam logic [ADDR_W-1:0] RESET_REGION_TOP   = 34'h0_8800_0000;

endpackage

>>> hdl/rpa_req_if.sv
// Request channel of the page allocator: valid/ready plus request payload.
// Depends on rpa_pkg.
interface rpa_req_if
   import rpa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ADDR_W-1:0] page_addr;

   modport source (output valid, output kind, output page_addr, input ready);
   modport sink   (input valid, input kind, input page_addr, output ready);
endinterface

>>> hdl/rpa_rsp_if.sv
// Response channel of the page allocator: valid/ready plus result payload.
// Depends on rpa_pkg.
interface rpa_rsp_if
   import rpa_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [ADDR_W-1:0]    result_addr;
   logic [CNT_OUT_W-1:0] count_after;

   modport source (output valid, output status, output result_addr, output count_after,
                   input ready);
   modport sink   (input valid, input status, input result_addr, input count_after,
                   output ready);
endinterface

>>> hdl/rpa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds until the next read enable. No dependencies.
module rpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/rpa_addr_check.sv
// Address check for free and add-reference requests: alignment, limits and
// page index range. Depends on rpa_pkg; PAGE_BYTES is a power of two.
module rpa_addr_check
   import rpa_pkg::*;
#(
   parameter int PAGE_COUNT = DEF_PAGE_COUNT,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
   input  logic [ADDR_W-1:0]             page_addr,
   input  logic [ADDR_W-1:0]             region_base,
   input  logic [ADDR_W-1:0]             first_usable,
   input  logic [ADDR_W-1:0]             region_top,
   output logic                          addr_ok,
   output logic [$clog2(PAGE_COUNT)-1:0] page_idx
);
   localparam int IDX_W      = $clog2(PAGE_COUNT);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   logic [ADDR_W-1:0] offset;
   logic [ADDR_W-1:0] page_full;
   logic              aligned;
   logic              in_limits;
   logic              in_range;

   always_comb begin
      offset    = page_addr - region_base;
      page_full = offset >> PAGE_SHIFT;
      aligned   = (page_addr[PAGE_SHIFT-1:0] == '0);
      in_limits = (page_addr >= first_usable) && (page_addr >= region_base) &&
                  (page_addr < region_top);
      in_range  = (64'(page_full) < 64'(PAGE_COUNT));
      addr_ok   = aligned && in_limits && in_range;
      page_idx  = page_full[IDX_W-1:0];
   end
endmodule

>>> hdl/refcounted_page_allocator.sv
// Reference-counted page allocator with a LIFO free list.
// Requests enter on req_ch: allocate pops the head page, free drops one
// reference or pushes the page back, add-reference raises the count. Each
// request gives exactly one item on rsp_ch with a status, the allocated
// address and the count of the touched page. The list starts empty; it is
// filled by issuing one free request per page.
// In the cycle an item is accepted the link and count memories are read;
// once their registered read data is back and the output register is free,
// the new count, link and head are written. No request is taken while one
// is in execution; the next is taken in the cycle after that write.
// The result sits in an output register. If the receiver stalls, one more
// request can be taken; it then waits after its memory read until the output
// register is free; no further request is taken until it is written there.
// After reset all PAGE_COUNT count entries are cleared in a pass,
// during which no request is taken; configuration writes go through at all
// times. Registers written on csr_*: 0 region base, 1 first usable address,
// 2 region top (exclusive). Write them only while the block is idle.
// Depends on rpa_pkg, rpa_req_if, rpa_rsp_if, rpa_ram and rpa_addr_check.
module refcounted_page_allocator
   import rpa_pkg::*;
#(
   parameter int PAGE_COUNT = DEF_PAGE_COUNT,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   rpa_req_if.sink              req_ch,
   rpa_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);
   localparam int IDX_W      = $clog2(PAGE_COUNT);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int EXT_W      = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(PAGE_COUNT - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic              nonempty_ff, nonempty_in;

   logic [ADDR_W-1:0] base_ff, first_ff, top_ff;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              ok_ff, ok_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [CNT_OUT_W-1:0] count_ff, count_in;

   logic                  accept;
   logic                  commit;
   logic                  chk_ok;
   logic [IDX_W-1:0]      chk_idx;
   logic [IDX_W-1:0]      link_rd;
   logic [COUNT_BITS-1:0] cnt_rd;
   logic [COUNT_BITS-1:0] cnt_new;
   logic [EXT_W-1:0]      cnt_ext;
   logic                  cnt_we;
   logic [IDX_W-1:0]      cnt_wr_addr;
   logic [COUNT_BITS-1:0] cnt_wr_data;
   logic                  link_we;
   logic [IDX_W-1:0]      link_wr_data;
   logic                  sat;

   rpa_addr_check #(
      .PAGE_COUNT(PAGE_COUNT),
      .PAGE_BYTES(PAGE_BYTES)
   ) u_check (
      .page_addr   (req_ch.page_addr),
      .region_base (base_ff),
      .first_usable(first_ff),
      .region_top  (top_ff),
      .addr_ok     (chk_ok),
      .page_idx    (chk_idx)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign commit       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   // Capture the request; allocate works on the current head page.
   always_comb begin
      kind_in = kind_ff;
      idx_in  = idx_ff;
      ok_in   = ok_ff;
      if (accept) begin
         kind_in = req_ch.kind;
         case (req_ch.kind)
            KIND_ALLOC: begin
               idx_in = head_ff;
               ok_in  = nonempty_ff;
            end
            KIND_FREE, KIND_ADDREF: begin
               idx_in = chk_idx;
               ok_in  = chk_ok;
            end
            default: begin
               idx_in = chk_idx;
               ok_in  = 1'b0;
            end
         endcase
      end
   end

   rpa_ram #(
      .WIDTH(IDX_W),
      .DEPTH(PAGE_COUNT)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (link_we),
      .wr_addr(idx_ff),
      .wr_data(link_wr_data),
      .rd_en  (accept),
      .rd_addr(idx_in),
      .rd_data(link_rd)
   );

   rpa_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(PAGE_COUNT)
   ) u_count_ram (
      .clock  (clock),
      .wr_en  (cnt_we),
      .wr_addr(cnt_wr_addr),
      .wr_data(cnt_wr_data),
      .rd_en  (accept),
      .rd_addr(idx_in),
      .rd_data(cnt_rd)
   );

   // Execute: new count, list update and result from the read data.
   always_comb begin
      sat          = (cnt_rd == COUNT_MAX);
      cnt_new      = cnt_rd;
      head_in      = head_ff;
      nonempty_in  = nonempty_ff;
      link_we      = 1'b0;
      link_wr_data = nonempty_ff ? head_ff : idx_ff;
      status_in    = ST_BAD_ADDR;
      addr_in      = '0;
      case (kind_ff)
         KIND_ALLOC: begin
            if (ok_ff) begin
               cnt_new   = sat ? cnt_rd : cnt_rd + COUNT_ONE;
               status_in = sat ? ST_SATURATED : ST_ALLOCATED;
               addr_in   = base_ff + (ADDR_W'(idx_ff) << PAGE_SHIFT);
               if (link_rd == idx_ff) begin
                  nonempty_in = 1'b0;
               end else begin
                  head_in = link_rd;
               end
            end else begin
               status_in = ST_NO_MEMORY;
            end
         end
         KIND_FREE: begin
            if (ok_ff) begin
               if (cnt_rd > COUNT_ONE) begin
                  cnt_new   = cnt_rd - COUNT_ONE;
                  status_in = ST_DROPPED;
               end else begin
                  cnt_new     = '0;
                  status_in   = ST_RETURNED;
                  link_we     = commit;
                  head_in     = idx_ff;
                  nonempty_in = 1'b1;
               end
            end
         end
         KIND_ADDREF: begin
            if (ok_ff) begin
               cnt_new   = sat ? cnt_rd : cnt_rd + COUNT_ONE;
               status_in = sat ? ST_SATURATED : ST_ADDED;
            end
         end
         default: begin
            status_in = ST_BAD_ADDR;
         end
      endcase
      if (!ok_ff) begin
         cnt_new = '0;
      end
      cnt_ext  = EXT_W'(cnt_new);
      count_in = cnt_ext[CNT_OUT_W-1:0];
   end

   // The clearing pass owns the count write port until it ends.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         cnt_we      = 1'b1;
         cnt_wr_addr = clr_ff;
         cnt_wr_data = '0;
      end else begin
         cnt_we      = commit && ok_ff;
         cnt_wr_addr = idx_ff;
         cnt_wr_data = cnt_new;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= RESET_REGION_BASE;
         first_ff     <= RESET_FIRST_USABLE;
         top_ff       <= RESET_REGION_TOP;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            head_ff     <= head_in;
            nonempty_ff <= nonempty_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_REGION_BASE:  base_ff  <= csr_wdata;
               REG_FIRST_USABLE: first_ff <= csr_wdata;
               REG_REGION_TOP:   top_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      idx_ff  <= idx_in;
      ok_ff   <= ok_in;
      if (commit) begin
         status_ff <= status_in;
         addr_ff   <= addr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.result_addr = addr_ff;
   assign rsp_ch.count_after = count_ff;
endmodule

>>> bench/tb.sv
// Self-checking bench for refcounted_page_allocator: directed and random
// request items, checked against a page/count ledger kept in the bench.
// Depends on rpa_pkg, rpa_req_if, rpa_rsp_if and the allocator RTL.
module tb
   import rpa_pkg::*;
();

   localparam int IDX_W = $clog2(DEF_PAGE_COUNT);
   localparam int COUNT_TOP = (1 << CNT_OUT_W) - 1;
   localparam int STALL_LIMIT = 150000;
   localparam longint unsigned PAGE = DEF_PAGE_BYTES;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

   typedef struct {
      logic [STATUS_W-1:0]  status;
      logic [ADDR_W-1:0]    addr;
      logic [CNT_OUT_W-1:0] count;
   } page_result_type;

   // Mirror of the allocator: free-list links, per-page counts and region
   // registers, plus the queue of results still owed by the block.
   class page_ledger;
      bit [IDX_W-1:0]     link_mem  [DEF_PAGE_COUNT];
      bit [CNT_OUT_W-1:0] count_mem [DEF_PAGE_COUNT];
      bit [IDX_W-1:0]     head;
      bit                 nonempty;
      bit [ADDR_W-1:0]    base  = RESET_REGION_BASE;
      bit [ADDR_W-1:0]    first = RESET_FIRST_USABLE;
      bit [ADDR_W-1:0]    top   = RESET_REGION_TOP;
      page_result_type    awaited[$];
      int                 errors;

      function bit locate(input logic [ADDR_W-1:0] a, output logic [IDX_W-1:0] idx);
         logic [ADDR_W-1:0] pg;
         idx = '0;
         if (a % DEF_PAGE_BYTES != 0 || a < first || a < base || a >= top) return 1'b0;
         pg = (a - base) / DEF_PAGE_BYTES;
         if (pg >= DEF_PAGE_COUNT) return 1'b0;
         idx = pg[IDX_W-1:0];
         return 1'b1;
      endfunction

      function void book_request(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] a);
         page_result_type e;
         logic [IDX_W-1:0] idx;
         bit [CNT_OUT_W-1:0] c;
         e = '{status: ST_BAD_ADDR, addr: '0, count: '0};
         if (kind == KIND_ALLOC) begin
            if (!nonempty) begin
               e.status = ST_NO_MEMORY;
            end else begin
               idx = head;
               // A page linked to itself is the last one on the list.
               if (link_mem[idx] == idx) nonempty = 1'b0;
               else head = link_mem[idx];
               e.addr = base + ADDR_W'(idx) * ADDR_W'(DEF_PAGE_BYTES);
               c = count_mem[idx];
               if (c == COUNT_TOP) begin
                  e.status = ST_SATURATED;
                  e.count  = c;
               end else begin
                  count_mem[idx] = c + 1'b1;
                  e.status = ST_ALLOCATED;
                  e.count  = c + 1'b1;
               end
            end
         end else if ((kind == KIND_FREE || kind == KIND_ADDREF) && locate(a, idx)) begin
            c = count_mem[idx];
            if (kind == KIND_FREE) begin
               if (c > 1) begin
                  count_mem[idx] = c - 1'b1;
                  e.status = ST_DROPPED;
                  e.count  = c - 1'b1;
               end else begin
                  // Pushed even when already listed; the links decide what follows.
                  count_mem[idx] = '0;
                  link_mem[idx]  = nonempty ? head : idx;
                  head     = idx;
                  nonempty = 1'b1;
                  e.status = ST_RETURNED;
               end
            end else if (c == COUNT_TOP) begin
               e.status = ST_SATURATED;
               e.count  = c;
            end else begin
               count_mem[idx] = c + 1'b1;
               e.status = ST_ADDED;
               e.count  = c + 1'b1;
            end
         end
         awaited.push_back(e);
      endfunction

      function void match_result(input logic [STATUS_W-1:0] st, input logic [ADDR_W-1:0] a,
                                 input logic [CNT_OUT_W-1:0] c);
         page_result_type e;
         if (awaited.size() == 0) begin
            $display("%0t: result item with none expected: status %0d address %h count %0d",
                     $time, st, a, c);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (st !== e.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, e.status, st);
            errors++;
         end
         if (a !== e.addr) begin
            $display("%0t: result_addr expected %h, actual %h", $time, e.addr, a);
            errors++;
         end
         if (c !== e.count) begin
            $display("%0t: count_after expected %0d, actual %0d", $time, e.count, c);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wdata;

   rpa_req_if req ();
   rpa_rsp_if rsp ();

   refcounted_page_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   page_ledger led;
   int tx_idle_pct;
   int rx_idle_pct;
   int stall_cycles = 0;

   // Legal pages of the current region setting and the addresses just outside it.
   logic [ADDR_W-1:0] legal_pages[$];
   logic [ADDR_W-1:0] lo_edge;
   logic [ADDR_W-1:0] lim_edge;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
         led.match_result(rsp.status, rsp.result_addr, rsp.count_after);
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[refcounted_page_allocator] ERROR");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] rand_addr();
      return {2'($urandom_range(3)), $urandom};
   endfunction

   task automatic send_req(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a);
      while ($urandom_range(99) < tx_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.kind      <= k;
      req.page_addr <= a;
      do @(posedge clock); while (req.ready !== 1'b1);
      led.book_request(k, a);
   endtask

   // Stop sending and wait until every expected result item is back.
   task automatic settle();
      req.valid <= 1'b0;
      while (led.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic refresh_pages();
      longint unsigned lo_b, lim_b, p, last_p;
      lo_b = (led.first > led.base) ? led.first : led.base;
      lo_b = (lo_b + PAGE - 1) / PAGE * PAGE;
      lim_b = longint'(led.base) + longint'(DEF_PAGE_COUNT) * PAGE;
      if (led.top < lim_b) lim_b = led.top;
      legal_pages.delete();
      for (p = lo_b; p < lim_b && legal_pages.size() < 12; p += PAGE)
         legal_pages.push_back(ADDR_W'(p));
      if (lo_b < lim_b) begin
         last_p = (lim_b - 1) / PAGE * PAGE;
         if (last_p >= p) legal_pages.push_back(ADDR_W'(last_p));
      end
      lo_edge  = ADDR_W'(lo_b - PAGE);
      lim_edge = ADDR_W'(lim_b);
   endtask

   task automatic program_region(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] f,
                                 input logic [ADDR_W-1:0] t);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= REG_REGION_BASE;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= REG_FIRST_USABLE;
      csr_wdata <= f;
      @(posedge clock);
      csr_index <= REG_REGION_TOP;
      csr_wdata <= t;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      led.base  = b;
      led.first = f;
      led.top   = t;
      refresh_pages();
   endtask

   task automatic populate();
      foreach (legal_pages[i]) send_req(KIND_FREE, legal_pages[i]);
   endtask

   // Mostly allocations and frees/add-references of legal pages, with some
   // malformed and boundary requests mixed in.
   task automatic random_traffic(input int n);
      int r;
      logic [KIND_W-1:0] k;
      logic [ADDR_W-1:0] a;
      repeat (n) begin
         r = $urandom_range(99);
         a = rand_addr();
         if (r < 38) begin
            k = KIND_ALLOC;
         end else if (legal_pages.size() != 0 && r < 88) begin
            a = legal_pages[$urandom_range(legal_pages.size() - 1)];
            k = (r < 72) ? KIND_FREE : KIND_ADDREF;
         end else begin
            k = $urandom_range(1) ? KIND_FREE : KIND_ADDREF;
            case ($urandom_range(4))
               0: k = KIND_W'($urandom);
               1: a = lo_edge;
               2: a = lim_edge;
               3: begin
                  if (legal_pages.size() != 0)
                     a = legal_pages[0] + ADDR_W'($urandom_range(PAGE - 1, 1));
               end
               default: a = a & ~ADDR_W'(PAGE - 1);
            endcase
         end
         send_req(k, a);
      end
   endtask

   initial begin
      logic [ADDR_W-1:0] b, f, t, target;
      logic [IDX_W-1:0] tidx;
      led = new;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = REG_REGION_BASE;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.kind = KIND_ALLOC;
      req.page_addr = '0;
      rsp.ready = 1'b0;
      tx_idle_pct = 6;
      rx_idle_pct = 81;
      refresh_pages();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset region settings; the block first clears its count memory.
      send_req(KIND_ALLOC, '0);                 // empty list
      send_req(KIND_UNKNOWN, '1);
      send_req(KIND_FREE, 34'h0_8000_0001);     // misaligned
      send_req(KIND_FREE, 34'h0_7FFF_F000);     // below the region
      send_req(KIND_FREE, 34'h0_8800_0000);     // at the top limit
      send_req(KIND_ADDREF, 34'h3_FFFF_F000);
      send_req(KIND_FREE, 34'h0_87FF_F000);     // last page
      send_req(KIND_FREE, 34'h0_8000_0000);
      send_req(KIND_FREE, 34'h0_8000_0000);     // double free of the head
      send_req(KIND_ALLOC, '1);
      send_req(KIND_ALLOC, '0);
      send_req(KIND_ADDREF, 34'h0_8000_0000);
      send_req(KIND_FREE, 34'h0_8000_0000);
      send_req(KIND_FREE, 34'h0_8000_0000);
      send_req(KIND_ADDREF, 34'h0_8000_5000);
      send_req(KIND_FREE, 34'h0_8000_5000);
      send_req(KIND_ALLOC, '0);
      send_req(KIND_ALLOC, '0);
      send_req(KIND_UNKNOWN, 34'h0_8000_1000);
      send_req(KIND_ADDREF, '0);
      send_req(KIND_FREE, 34'h0_87FF_F000);
      send_req(KIND_ALLOC, '0);
      populate();
      random_traffic(280);

      // Whole address space, limited by the page count alone.
      program_region('0, '0, '1);
      populate();
      random_traffic(280);

      tx_idle_pct = 81;
      rx_idle_pct = 6;
      // Misaligned base, first usable above it.
      program_region(34'h2_0000_0ABC, 34'h2_0000_5000, 34'h2_0001_8000);
      populate();
      random_traffic(300);

      // No legal page; allocated addresses wrap past the top of the space.
      program_region('1, '1, '0);
      random_traffic(120);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      b = {2'($urandom_range(2)), $urandom};
      f = b + ADDR_W'($urandom_range(8)) * ADDR_W'(PAGE) + ADDR_W'($urandom_range(1));
      t = f + ADDR_W'($urandom_range(40, 6)) * ADDR_W'(PAGE);
      program_region(b, f, t);
      populate();
      // Put one page on the list, raise its count a few times, then pop it.
      target = legal_pages[0];
      void'(led.locate(target, tidx));
      while (led.count_mem[tidx] > 1) send_req(KIND_FREE, target);
      send_req(KIND_FREE, target);
      repeat (5) send_req(KIND_ADDREF, target);
      send_req(KIND_ALLOC, rand_addr());
      random_traffic(300);

      // First usable below the base, so the base check alone rejects some pages.
      program_region(34'h1_0000_0000, '0, 34'h1_0002_0000);
      populate();
      random_traffic(300);

      settle();
      if (led.errors == 0) begin
         $display("[refcounted_page_allocator] OK");
      end else begin
         $display("[refcounted_page_allocator] ERROR");
      end
      $finish;
   end

endmodule
